// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the display power scheduler RTL.
// Each macro expects signals named clock and reset in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define DPS_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("dps assertion failed");

// Check that an antecedent is followed in the next cycle by a consequent.
`define DPS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dps assertion failed");

`endif

// ----- rtl/dps_pkg.sv -----
// Package for the display power scheduler: widths, reset values, register
// indexes and the structs that carry configuration and transactions to the engine.
package dps_pkg;

   localparam int MS_W      = 32;
   localparam int MINUTE_W  = 11;
   localparam int IDLE_W    = 16;
   localparam int BL_W      = 7;
   localparam int MV_W      = 12;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   localparam logic [MS_W-1:0]     MARK_PERIOD_MS = 32'd1000;
   localparam logic [MV_W-1:0]     BASE_MV        = 12'd2500;

   localparam logic                RST_SCHEDULE_ENABLE = 1'b1;
   localparam logic [IDLE_W-1:0]   RST_IDLE_SECONDS    = 16'd60;
   localparam logic [MINUTE_W-1:0] RST_ON_MINUTE       = 11'd420;
   localparam logic [MINUTE_W-1:0] RST_OFF_MINUTE      = 11'd1320;
   localparam logic [BL_W-1:0]     RST_BACKLIGHT       = 7'd100;

   localparam logic [CSR_IDX_W-1:0] CSR_SCHEDULE_ENABLE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_SECONDS    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ON_MINUTE       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OFF_MINUTE      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKLIGHT       = 3'd4;

   typedef struct packed {
      logic                schedule_enable;
      logic [IDLE_W-1:0]   idle_seconds;
      logic [MINUTE_W-1:0] on_minute;
      logic [MINUTE_W-1:0] off_minute;
      logic [BL_W-1:0]     backlight_percent;
   } dps_cfg_type;

   typedef struct packed {
      logic                valid;
      logic [MS_W-1:0]     now_ms;
      logic [MINUTE_W-1:0] minute_of_day;
      logic                button_pressed;
   } dps_item_type;

endpackage

// ----- rtl/display_power_scheduler_top.sv -----
// Display power scheduler: accepts one transaction per clock while req_stall
// is low. A transaction is captured in the input register at acceptance,
// evaluated combinationally against the scheduler state, and its result is
// loaded into the result register when the engine takes it; the sustained
// rate is one transaction per cycle, limited only by the result channel's
// stall. Configuration writes take effect on the next edge; write them only
// while no transaction is in flight. Reset needs no clearing pass.
module display_power_scheduler_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [dps_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dps_pkg::CSR_DAT_W-1:0]     csr_write_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [dps_pkg::MS_W-1:0]          req_now_ms,
   input  logic [dps_pkg::MINUTE_W-1:0]      req_minute_of_day,
   input  logic                              req_button_pressed,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_display_lit,
   output logic                              rsp_power_changed,
   output logic [dps_pkg::MV_W-1:0]          rsp_drive_millivolts,
   output logic                              rsp_press_consumed
);
   import dps_pkg::*;

   dps_cfg_type  cfg;
   dps_item_type item_ff, item_in;
   logic         take;
   logic         req_fire;

   dps_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // Hold a captured transaction until the engine takes it.
   assign req_stall = item_ff.valid && !take;
   assign req_fire  = req_valid && !req_stall;

   always_comb begin
      item_in       = item_ff;
      item_in.valid = req_fire || (item_ff.valid && !take);
      if (req_fire) begin
         item_in.now_ms         = req_now_ms;
         item_in.minute_of_day  = req_minute_of_day;
         item_in.button_pressed = req_button_pressed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else begin
         item_ff.valid <= item_in.valid;
      end
      item_ff.now_ms         <= item_in.now_ms;
      item_ff.minute_of_day  <= item_in.minute_of_day;
      item_ff.button_pressed <= item_in.button_pressed;
   end

   dps_engine u_engine (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg),
      .item                 (item_ff),
      .take                 (take),
      .rsp_stall            (rsp_stall),
      .rsp_valid            (rsp_valid),
      .rsp_display_lit      (rsp_display_lit),
      .rsp_power_changed    (rsp_power_changed),
      .rsp_drive_millivolts (rsp_drive_millivolts),
      .rsp_press_consumed   (rsp_press_consumed)
   );

endmodule

// ----- rtl/dps_csr.sv -----
// Configuration registers of the display power scheduler.
// Depends on dps_pkg for register indexes, widths and reset values.
module dps_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [dps_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dps_pkg::CSR_DAT_W-1:0]  csr_write_data,
   output dps_pkg::dps_cfg_type           cfg
);
   import dps_pkg::*;

   dps_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SCHEDULE_ENABLE: cfg_in.schedule_enable   = csr_write_data[0];
            CSR_IDLE_SECONDS:    cfg_in.idle_seconds      = csr_write_data[IDLE_W-1:0];
            CSR_ON_MINUTE:       cfg_in.on_minute         = csr_write_data[MINUTE_W-1:0];
            CSR_OFF_MINUTE:      cfg_in.off_minute        = csr_write_data[MINUTE_W-1:0];
            CSR_BACKLIGHT:       cfg_in.backlight_percent = csr_write_data[BL_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.schedule_enable   <= RST_SCHEDULE_ENABLE;
         cfg_ff.idle_seconds      <= RST_IDLE_SECONDS;
         cfg_ff.on_minute         <= RST_ON_MINUTE;
         cfg_ff.off_minute        <= RST_OFF_MINUTE;
         cfg_ff.backlight_percent <= RST_BACKLIGHT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/dps_engine.sv -----
// Scheduler state, single-pass update logic and result register.
// Depends on dps_pkg and assert_macros.svh.
module dps_engine (
   input  logic                              clock,
   input  logic                              reset,
   input  dps_pkg::dps_cfg_type              cfg,
   input  dps_pkg::dps_item_type             item,
   output logic                              take,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic                              rsp_display_lit,
   output logic                              rsp_power_changed,
   output logic [dps_pkg::MV_W-1:0]          rsp_drive_millivolts,
   output logic                              rsp_press_consumed
);
   import dps_pkg::*;

   `include "assert_macros.svh"

   logic [MS_W-1:0]   last_mark_ff, last_mark_in;
   logic              lit_ff, lit_in;
   logic [IDLE_W-1:0] countdown_ff, countdown_in;

   logic              out_vld_ff, out_vld_in;
   logic              out_lit_ff, out_lit_in;
   logic              out_chg_ff, out_chg_in;
   logic [MV_W-1:0]   out_mv_ff, out_mv_in;
   logic              out_used_ff, out_used_in;

   logic [MS_W-1:0]   elapsed;
   logic              mark;
   logic              window_lit;
   logic              lit_mid;
   logic [MV_W-1:0]   lit_mv;

   // Strict window when on is below off; otherwise it wraps past midnight and includes both bounds.
   always_comb begin
      if (cfg.on_minute < cfg.off_minute) begin
         window_lit = (cfg.on_minute < item.minute_of_day) &&
                      (item.minute_of_day < cfg.off_minute);
      end else begin
         window_lit = !((cfg.off_minute < item.minute_of_day) &&
                        (item.minute_of_day < cfg.on_minute));
      end
   end

   assign elapsed = item.now_ms - last_mark_ff;
   assign mark    = elapsed > MARK_PERIOD_MS;
   assign lit_mv  = {cfg.backlight_percent, 3'b000} + BASE_MV;

   // Advance when the result register is empty or being drained.
   assign take = item.valid && (!out_vld_ff || !rsp_stall);

   always_comb begin
      last_mark_in = last_mark_ff;
      lit_in       = lit_ff;
      countdown_in = countdown_ff;
      lit_mid      = lit_ff;
      out_used_in  = 1'b0;
      if (cfg.schedule_enable) begin
         if (mark) begin
            last_mark_in = item.now_ms;
            if (countdown_ff == '0) begin
               lit_mid = window_lit;
            end else begin
               countdown_in = countdown_ff - 1'b1;
            end
         end
         lit_in = lit_mid;
         if (item.button_pressed) begin
            countdown_in = cfg.idle_seconds;
            lit_in       = 1'b1;
            out_used_in  = !lit_mid;
         end
      end else begin
         lit_in = 1'b1;
      end
      out_lit_in = lit_in;
      out_chg_in = lit_in != lit_ff;
      out_mv_in  = lit_in ? lit_mv : BASE_MV;
   end

   assign out_vld_in = take ? 1'b1 : (out_vld_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         last_mark_ff <= '0;
         lit_ff       <= 1'b1;
         countdown_ff <= RST_IDLE_SECONDS;
         out_vld_ff   <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
         if (take) begin
            last_mark_ff <= last_mark_in;
            lit_ff       <= lit_in;
            countdown_ff <= countdown_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_lit_ff  <= out_lit_in;
         out_chg_ff  <= out_chg_in;
         out_mv_ff   <= out_mv_in;
         out_used_ff <= out_used_in;
      end
   end

   assign rsp_valid            = out_vld_ff;
   assign rsp_display_lit      = out_lit_ff;
   assign rsp_power_changed    = out_chg_ff;
   assign rsp_drive_millivolts = out_mv_ff;
   assign rsp_press_consumed   = out_used_ff;

   `DPS_ASSERT_NEXT(a_disabled_forces_on, take && !cfg.schedule_enable, lit_ff)
   `DPS_ASSERT_NEXT(a_state_holds_idle, !take, $stable(countdown_ff) && $stable(last_mark_ff))
   `DPS_ASSERT_NEXT(a_change_matches_state, take, out_chg_ff == (lit_ff != $past(lit_ff)))
   `DPS_ASSERT(a_result_tracks_state, !(take && out_vld_ff && rsp_stall))

endmodule
